// ----- rtl/core/m3i_pkg.sv -----
// ----------------------------------------------------------------------------
// m3i_pkg: shared types and defaults for the 3x3 matrix inverse
// Default element format, queue depth, back-end state encoding and the
// control group that drives the divider lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package m3i_pkg;

  // Default element format: signed Q16.16
  localparam int ELEM_WIDTH_DEF  = 32;
  localparam int FRAC_BITS_DEF   = 16;
  // Entries between front and back
  localparam int QUEUE_DEPTH_DEF = 2;
  // Elements of a 3x3 matrix
  localparam int NUM_ELEMS       = 9;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } back_state_e;

  // Control from the back-end sequencer to every divider lane
  typedef struct packed {
    logic load;
    logic step;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/m3i_front.sv -----
// ----------------------------------------------------------------------------
// m3i_front: cofactor and determinant pipeline
// Six-stage pipeline: input register, 2x2 minor products, cofactors,
// split determinant partial products, determinant terms, determinant sum.
// All stages advance together; the pipeline stalls when its last stage
// holds a request that the queue cannot take.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_front import m3i_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push_i,
  output logic                                   full_o,
  input  wire logic [NUM_ELEMS*ELEM_WIDTH-1:0]   elems_i,
  output logic                                   q_push_o,
  input  wire logic                              q_full_i,
  output logic [NUM_ELEMS*(2*ELEM_WIDTH+1)+3*ELEM_WIDTH+1:0] q_data_o
);

  localparam int W   = ELEM_WIDTH;
  localparam int PW  = 2 * W;       // minor product
  localparam int CW  = 2 * W + 1;   // cofactor
  localparam int PPW = 2 * W + 1;   // determinant partial product
  localparam int DW  = 3 * W + 2;   // determinant

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  logic signed [W-1:0]   e_q   [NUM_ELEMS];
  logic signed [PW-1:0]  pa_d  [NUM_ELEMS];
  logic signed [PW-1:0]  pb_d  [NUM_ELEMS];
  logic signed [PW-1:0]  pa_q  [NUM_ELEMS];
  logic signed [PW-1:0]  pb_q  [NUM_ELEMS];
  logic signed [W-1:0]   r02_q [3];
  logic signed [W-1:0]   r03_q [3];
  logic signed [CW-1:0]  cof3_q [NUM_ELEMS];
  logic signed [CW-1:0]  cof4_q [NUM_ELEMS];
  logic signed [CW-1:0]  cof5_q [NUM_ELEMS];
  logic signed [CW-1:0]  cof6_q [NUM_ELEMS];
  logic signed [PPW-1:0] pl_d  [3];
  logic signed [PPW-1:0] ph_d  [3];
  logic signed [PPW-1:0] pl_q  [3];
  logic signed [PPW-1:0] ph_q  [3];
  logic signed [DW-1:0]  term_d [3];
  logic signed [DW-1:0]  term_q [3];
  logic signed [DW-1:0]  det_q;

  // Stall only when the last stage is blocked by a full queue
  assign en       = !(v6_q && q_full_i);
  assign full_o   = !en;
  assign q_push_o = v6_q && !q_full_i;

  // Valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= push_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // Minor products: C(i,j) = a - b with cyclic indices
  for (genvar c = 0; c < NUM_ELEMS; c++) begin : g_minor
    localparam int I  = c / 3;
    localparam int J  = c % 3;
    localparam int I1 = (I + 1) % 3;
    localparam int I2 = (I + 2) % 3;
    localparam int J1 = (J + 1) % 3;
    localparam int J2 = (J + 2) % 3;
    assign pa_d[c] = e_q[I1*3+J1] * e_q[I2*3+J2];
    assign pb_d[c] = e_q[I1*3+J2] * e_q[I2*3+J1];
  end

  // Row-0 cofactors split into low (unsigned) and high (signed) halves
  for (genvar k = 0; k < 3; k++) begin : g_part
    assign pl_d[k] = r03_q[k] * $signed({1'b0, cof3_q[k][W-1:0]});
    assign ph_d[k] = r03_q[k] * $signed(cof3_q[k][CW-1:W]);
    assign term_d[k] = (DW'(ph_q[k]) <<< W) + DW'(pl_q[k]);
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NUM_ELEMS; c++) begin
        e_q[c]    <= $signed(elems_i[c*W +: W]);
        pa_q[c]   <= pa_d[c];
        pb_q[c]   <= pb_d[c];
        cof3_q[c] <= CW'(pa_q[c]) - CW'(pb_q[c]);
        cof4_q[c] <= cof3_q[c];
        cof5_q[c] <= cof4_q[c];
        cof6_q[c] <= cof5_q[c];
      end
      for (int k = 0; k < 3; k++) begin
        r02_q[k]  <= e_q[k];
        r03_q[k]  <= r02_q[k];
        pl_q[k]   <= pl_d[k];
        ph_q[k]   <= ph_d[k];
        term_q[k] <= term_d[k];
      end
      det_q <= term_q[0] + term_q[1] + term_q[2];
    end
  end

  // Queue entry: cofactors above, determinant in the low bits
  always_comb begin
    q_data_o[DW-1:0] = det_q;
    for (int c = 0; c < NUM_ELEMS; c++) begin
      q_data_o[DW + c*CW +: CW] = cof6_q[c];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/m3i_queue.sv -----
// ----------------------------------------------------------------------------
// m3i_queue: short show-ahead queue between front and back
// Register-based FIFO; the head entry is always on data_o while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/m3i_div_lane.sv -----
// ----------------------------------------------------------------------------
// m3i_div_lane: one restoring-division lane
// Divides |cofactor| * 2^(2F) by |det|, one quotient bit per step, most
// significant first, then applies the sign and saturates to the element range.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_div_lane import m3i_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire lane_ctrl_t                    ctrl_i,
  input  wire logic signed [2*ELEM_WIDTH:0]  cof_i,
  input  wire logic                          det_neg_i,
  input  wire logic [4*ELEM_WIDTH:0]         dsh_i,
  output logic [ELEM_WIDTH-1:0]              res_o
);

  localparam int W   = ELEM_WIDTH;
  localparam int CW  = 2 * W + 1;
  localparam int NW  = 2 * W + 2 * FRAC_BITS;
  localparam int DSW = 4 * W + 1;
  localparam int XW  = (NW > DSW) ? NW : DSW;
  localparam int QW  = W + 2;

  logic [CW-1:0] cabs;
  logic [NW-1:0] r_q;
  logic [QW-1:0] q_q;
  logic          neg_q;
  logic          ge;
  logic [XW-1:0] diff;
  logic [QW-1:0] lim, mag, neg_val;

  // Numerator magnitude
  assign cabs = cof_i[CW-1] ? (~cof_i + CW'(1)) : cof_i;

  // Trial subtract
  assign ge   = XW'(r_q) >= XW'(dsh_i);
  assign diff = XW'(r_q) - XW'(dsh_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      r_q   <= NW'(cabs[2*W-1:0]) << (2 * FRAC_BITS);
      q_q   <= '0;
      neg_q <= cof_i[CW-1] ^ det_neg_i;
    end else if (ctrl_i.step) begin
      if (ge) begin
        r_q <= diff[NW-1:0];
      end
      q_q <= {q_q[QW-2:0], ge};
    end
  end

  // Sign and saturation
  assign lim = QW'(1) << (W - 1);
  always_comb begin
    if (neg_q) begin
      mag = (q_q > lim) ? lim : q_q;
    end else begin
      mag = (q_q > (lim - 1'b1)) ? (lim - 1'b1) : q_q;
    end
    neg_val = QW'(0) - mag;
    res_o   = neg_q ? neg_val[W-1:0] : mag[W-1:0];
  end

endmodule

`default_nettype wire

// ----- rtl/core/m3i_back.sv -----
// ----------------------------------------------------------------------------
// m3i_back: division back end
// Takes one entry from the queue, runs nine divider lanes in parallel over a
// shared shifting divisor, and writes the transposed quotients into a
// one-entry output register.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_back import m3i_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  q_empty_i,
  input  wire logic [NUM_ELEMS*(2*ELEM_WIDTH+1)+3*ELEM_WIDTH+1:0] q_data_i,
  output logic                                       q_pop_o,
  input  wire logic                                  pop_i,
  output logic                                       empty_o,
  output logic [NUM_ELEMS*ELEM_WIDTH-1:0]            res_o,
  output logic                                       singular_o
);

  localparam int W    = ELEM_WIDTH;
  localparam int CW   = 2 * W + 1;
  localparam int DW   = 3 * W + 2;
  localparam int DSW  = 4 * W + 1;
  localparam int CNTW = $clog2(W + 2);

  back_state_e state_q, state_d;
  lane_ctrl_t  lane_ctrl;
  logic [CNTW-1:0] cnt_q;
  logic [DSW-1:0]  dsh_q;
  logic            sing_q;
  logic            out_valid_q, out_sing_q, out_wr, out_free;
  logic [NUM_ELEMS*W-1:0] out_q, lane_res;
  logic signed [DW-1:0] det_s;
  logic [DW-1:0]   det_abs;
  logic            det_zero, last_step;

  // Head-of-queue determinant
  assign det_s    = $signed(q_data_i[DW-1:0]);
  assign det_abs  = det_s[DW-1] ? (~det_s + DW'(1)) : det_s;
  assign det_zero = (det_s == '0);
  assign last_step = (cnt_q == CNTW'(W + 1));
  assign out_free = !out_valid_q || pop_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (!q_empty_i) state_d = det_zero ? ST_DONE : ST_RUN;
      ST_RUN:  if (last_step) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    lane_ctrl.load = 1'b0;
    lane_ctrl.step = 1'b0;
    out_wr         = 1'b0;
    unique case (state_q)
      ST_IDLE: lane_ctrl.load = !q_empty_i;
      ST_RUN:  lane_ctrl.step = 1'b1;
      ST_DONE: out_wr = out_free;
      default: ;
    endcase
  end

  assign q_pop_o = lane_ctrl.load;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Shared divisor, step count and result register
  always_ff @(posedge clk_i) begin
    if (lane_ctrl.load) begin
      dsh_q  <= DSW'(det_abs[3*W-1:0]) << (W + 1);
      cnt_q  <= '0;
      sing_q <= det_zero;
    end else if (lane_ctrl.step) begin
      dsh_q <= dsh_q >> 1;
      cnt_q <= cnt_q + 1'b1;
    end
    if (out_wr) begin
      out_q      <= sing_q ? '0 : lane_res;
      out_sing_q <= sing_q;
    end
  end

  // Lanes; output (j,i) takes cofactor (i,j)
  for (genvar l = 0; l < NUM_ELEMS; l++) begin : g_lane
    localparam int SRC = (l % 3) * 3 + (l / 3);
    m3i_div_lane #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .ctrl_i    (lane_ctrl),
      .cof_i     ($signed(q_data_i[DW + SRC*CW +: CW])),
      .det_neg_i (det_s[DW-1]),
      .dsh_i     (dsh_q),
      .res_o     (lane_res[l*W +: W])
    );
  end

  assign empty_o    = !out_valid_q;
  assign res_o      = out_q;
  assign singular_o = out_sing_q;

endmodule

`default_nettype wire

// ----- rtl/core/matrix3x3_inverse_top.sv -----
// Throughput is set by the nine bit-serial division lanes, which take one matrix
// at a time (default elements Q16.16); a singular matrix skips the division steps.
// The front pipeline accepts new requests while the back end divides, until it
// stalls on a full queue.
// Reset clears all valid and state flags; queue and result register are empty.
// ----------------------------------------------------------------------------
// matrix3x3_inverse_top: 3x3 fixed-point matrix inverse
// Adjugate over determinant; quotients truncate toward zero and saturate.
// A zero determinant returns the zero matrix with singular set.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix3x3_inverse_top import m3i_pkg::*; #(
  parameter int ELEM_WIDTH  = ELEM_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  output logic                              full_o,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r0c0_i,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r0c1_i,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r0c2_i,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r1c0_i,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r1c1_i,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r1c2_i,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r2c0_i,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r2c1_i,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r2c2_i,
  output logic                              empty_o,
  input  wire logic                         pop_i,
  output logic signed [ELEM_WIDTH-1:0]      out_r0c0_o,
  output logic signed [ELEM_WIDTH-1:0]      out_r0c1_o,
  output logic signed [ELEM_WIDTH-1:0]      out_r0c2_o,
  output logic signed [ELEM_WIDTH-1:0]      out_r1c0_o,
  output logic signed [ELEM_WIDTH-1:0]      out_r1c1_o,
  output logic signed [ELEM_WIDTH-1:0]      out_r1c2_o,
  output logic signed [ELEM_WIDTH-1:0]      out_r2c0_o,
  output logic signed [ELEM_WIDTH-1:0]      out_r2c1_o,
  output logic signed [ELEM_WIDTH-1:0]      out_r2c2_o,
  output logic                              singular_o
);

  localparam int W   = ELEM_WIDTH;
  localparam int QEW = NUM_ELEMS * (2 * W + 1) + 3 * W + 2;

  logic [NUM_ELEMS*W-1:0] elems, res;
  logic [QEW-1:0]         fq_data, bq_data;
  logic                   q_push, q_full, q_pop, q_empty;

  // Element c sits at bits [c*W +: W], row-major
  assign elems = {in_r2c2_i, in_r2c1_i, in_r2c0_i,
                  in_r1c2_i, in_r1c1_i, in_r1c0_i,
                  in_r0c2_i, in_r0c1_i, in_r0c0_i};

  m3i_front #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .full_o   (full_o),
    .elems_i  (elems),
    .q_push_o (q_push),
    .q_full_i (q_full),
    .q_data_o (fq_data)
  );

  m3i_queue #(
    .WIDTH (QEW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (fq_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (bq_data),
    .empty_o (q_empty)
  );

  m3i_back #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (bq_data),
    .q_pop_o    (q_pop),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .res_o      (res),
    .singular_o (singular_o)
  );

  // Result fields, row-major
  assign out_r0c0_o = $signed(res[0*W +: W]);
  assign out_r0c1_o = $signed(res[1*W +: W]);
  assign out_r0c2_o = $signed(res[2*W +: W]);
  assign out_r1c0_o = $signed(res[3*W +: W]);
  assign out_r1c1_o = $signed(res[4*W +: W]);
  assign out_r1c2_o = $signed(res[5*W +: W]);
  assign out_r2c0_o = $signed(res[6*W +: W]);
  assign out_r2c1_o = $signed(res[7*W +: W]);
  assign out_r2c2_o = $signed(res[8*W +: W]);

endmodule

`default_nettype wire

// ----- tb/matrix3x3_inverse_top_test.sv -----
// ----------------------------------------------------------------------------
// matrix3x3_inverse_top_test: self-checking bench for the 3x3 matrix inverse
// Pushes directed and random Q16.16 matrices through the queue interface,
// predicts each inverse with exact wide arithmetic and checks every result
// field in order. Both sides stall at random, but for one unstalled random run.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix3x3_inverse_top_test;
  import m3i_pkg::*;

  localparam int EW = ELEM_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int WW = 256;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic signed [EW-1:0] elem_t;
  typedef elem_t mat_t [9];

  typedef struct {
    elem_t elem [9];
    logic  singular;
  } inverse_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  elem_t in_e [9];
  elem_t out_e [9];
  logic singular;

  inverse_t inverse_q [$];
  int  fail_cnt = 0;
  int  cycle_cnt = 0;
  bit  stall_en = 1'b1;

  always #10 clk = ~clk;

  initial for (int k = 0; k < 9; k++) in_e[k] = '0;

  matrix3x3_inverse_top dut (
    .clk_i(clk), .rst_ni(rst_n), .push_i(push), .full_o(full),
    .in_r0c0_i(in_e[0]), .in_r0c1_i(in_e[1]), .in_r0c2_i(in_e[2]),
    .in_r1c0_i(in_e[3]), .in_r1c1_i(in_e[4]), .in_r1c2_i(in_e[5]),
    .in_r2c0_i(in_e[6]), .in_r2c1_i(in_e[7]), .in_r2c2_i(in_e[8]),
    .empty_o(empty), .pop_i(pop),
    .out_r0c0_o(out_e[0]), .out_r0c1_o(out_e[1]), .out_r0c2_o(out_e[2]),
    .out_r1c0_o(out_e[3]), .out_r1c1_o(out_e[4]), .out_r1c2_o(out_e[5]),
    .out_r2c0_o(out_e[6]), .out_r2c1_o(out_e[7]), .out_r2c2_o(out_e[8]),
    .singular_o(singular)
  );

  // Exact cofactor of entry (i,j), cyclic index form
  function automatic logic signed [WW-1:0] cofactor(mat_t m, int i, int j);
    int i1, i2, j1, j2;
    logic signed [WW-1:0] a, b, c, d;
    i1 = (i + 1) % 3; i2 = (i + 2) % 3; j1 = (j + 1) % 3; j2 = (j + 2) % 3;
    a = m[i1*3+j1]; b = m[i2*3+j2]; c = m[i1*3+j2]; d = m[i2*3+j1];
    return a * b - c * d;
  endfunction

  // Adjugate over determinant, truncated toward zero and saturated
  function automatic inverse_t predict_inverse(mat_t m);
    inverse_t r;
    logic signed [WW-1:0] det, num, quo, e0;
    det = '0;
    for (int i = 0; i < 3; i++) begin
      e0 = m[i];
      det += e0 * cofactor(m, 0, i);
    end
    r.singular = (det == 0);
    for (int k = 0; k < 9; k++) r.elem[k] = '0;
    if (!r.singular) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          num = cofactor(m, i, j) <<< (2 * FB);
          quo = num / det;
          if (quo > $signed({{(WW-EW){1'b0}}, 1'b0, {(EW-1){1'b1}}}))
            r.elem[j*3+i] = {1'b0, {(EW-1){1'b1}}};
          else if (quo < -$signed({{(WW-EW){1'b0}}, 1'b1, {(EW-1){1'b0}}}))
            r.elem[j*3+i] = {1'b1, {(EW-1){1'b0}}};
          else
            r.elem[j*3+i] = quo[EW-1:0];
        end
      end
    end
    return r;
  endfunction

  // Send one matrix request; expectation queued at acceptance.
  // Called and returns at a falling edge; push stays high for back-to-back.
  task automatic send_matrix(mat_t m);
    while (stall_en && $urandom_range(99) < 13) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    for (int k = 0; k < 9; k++) in_e[k] <= m[k];
    @(posedge clk);
    while (full) @(posedge clk);
    inverse_q.push_back(predict_inverse(m));
    @(negedge clk);
  endtask

  // Result side: random pop, compare against oldest expectation
  initial begin
    inverse_t exp_r;
    forever begin
      @(negedge clk);
      pop <= stall_en ? ($urandom_range(99) >= 13) : 1'b1;
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        if (inverse_q.size() == 0) begin
          $error("result with no request pending");
          fail_cnt++;
        end else begin
          exp_r = inverse_q.pop_front();
          for (int k = 0; k < 9; k++)
            if (out_e[k] !== exp_r.elem[k]) begin
              $error("out_r%0dc%0d exp %0d got %0d", k / 3, k % 3, exp_r.elem[k], out_e[k]);
              fail_cnt++;
            end
          if (singular !== exp_r.singular) begin
            $error("singular exp %0b got %0b", exp_r.singular, singular);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic elem_t rand_elem();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $signed($urandom_range(8)) <<< FB;
      2: return -($signed($urandom_range(8)) <<< FB);
      3: return $signed($urandom_range(65535)) - 32768;
      4: return {1'b0, {(EW-1){1'b1}}} - $urandom_range(3);
      default: return $signed($urandom_range(1 << 20)) - (1 << 19);
    endcase
  endfunction

  task automatic test_directed();
    mat_t m;
    // identity, scaled diagonal, all-zero, extremes, rank-deficient
    for (int t = 0; t < 12; t++) begin
      for (int k = 0; k < 9; k++) m[k] = '0;
      case (t)
        0: begin m[0] = 1 << FB; m[4] = 1 << FB; m[8] = 1 << FB; end
        1: begin m[0] = 2 << FB; m[4] = -(4 << FB); m[8] = 1 << (FB - 1); end
        2: ;
        3: for (int k = 0; k < 9; k++) m[k] = {1'b1, {(EW-1){1'b0}}};
        4: begin m[0] = 1; m[4] = 1; m[8] = 1; end
        5: begin m[0] = -1; m[4] = 1; m[8] = 1; end
        6: begin
          m[0] = {1'b0, {(EW-1){1'b1}}}; m[4] = m[0]; m[8] = m[0];
        end
        7: begin
          m[0] = {1'b1, {(EW-1){1'b0}}}; m[4] = m[0]; m[8] = m[0];
        end
        8: for (int k = 0; k < 9; k++) m[k] = (k + 1) << FB;
        9: begin
          for (int k = 0; k < 9; k++) m[k] = $urandom();
          for (int k = 0; k < 3; k++) m[6+k] = m[k];
        end
        10: for (int k = 0; k < 9; k++) m[k] = '1;
        default: begin
          m[1] = 1 << FB; m[3] = {1'b1, {(EW-1){1'b0}}}; m[8] = {1'b0, {(EW-1){1'b1}}};
        end
      endcase
      send_matrix(m);
    end
  endtask

  task automatic test_random(int n);
    mat_t m;
    for (int t = 0; t < n; t++) begin
      for (int k = 0; k < 9; k++) m[k] = rand_elem();
      if ($urandom_range(9) == 0) for (int k = 0; k < 3; k++) m[3+k] = m[k];
      send_matrix(m);
    end
  endtask

  // Stop sending and wait for every expected result; returns at a falling edge
  task automatic drain_results();
    push <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    drain_results();
    test_random(150);
    stall_en = 1'b0;
    test_random(80);
    stall_en = 1'b1;
    test_random(160);
    drain_results();
    repeat (EW + 20) @(posedge clk);
    if (fail_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
